>>> design/rts_pkg.sv
// Shared constants and types for the redirection token splitter.
// No dependencies; compile first.
`default_nettype none

package rts_pkg;

  localparam int CH_W     = 8;
  localparam int KIND_W   = 3;
  localparam int START_W  = 12;
  localparam int LEN_W    = 13;
  localparam int MAX_LEN_DEFAULT = 4096;

  // Token kinds on the result channel
  localparam logic [KIND_W-1:0] KIND_WORD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GT     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GTGT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LT     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LTLT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd5;

  // Quote tracking
  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  // Pending operator held for one byte of lookahead
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_GT   = 2'd1;
  localparam logic [1:0] PEND_LT   = 2'd2;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CH_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CH_W-1:0] CH_SQ    = 8'h27;
  localparam logic [CH_W-1:0] CH_DQ    = 8'h22;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start_res;
    logic [LEN_W-1:0]   length;
    logic               failed;
    logic               last;
  } rts_res_t;

endpackage

`default_nettype wire

>>> design/rts_ifs.sv
// Valid/ready channel interfaces: byte input and token output.
// Depends on rts_pkg.
`default_nettype none

interface rts_in_if;
  import rts_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface rts_out_if;
  import rts_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [START_W-1:0] start_res;
  logic [LEN_W-1:0]   length;
  logic               failed;
  logic               last;
  modport source (output valid, output kind, output start_res, output length,
                  output failed, output last, input ready);
  modport sink   (input valid, input kind, input start_res, input length,
                  input failed, input last, output ready);
endinterface

`default_nettype wire

>>> design/redirection_token_splitter.sv
// Redirection token splitter top level: byte scanner and result queue.
// Depends on rts_pkg and the interfaces in rts_ifs.sv.
//
//   channel  dir  payload                                  beat
//   src      in   ch[7:0]                                  one string byte
//   tok      out  kind, start_res, length, failed, last    one token
//
// One byte is taken per cycle; the scanner decides its zero, one or two
// tokens in the same cycle and writes them into a four-entry queue.
// src.ready is high while the queue has room for two tokens, so bytes flow
// back to back unless tok stalls and the queue fills. Tokens leave one per
// ready cycle. Reset (rst, synchronous) empties the queue and returns the
// scanner to the start of a string, outside quotes, with nothing pending.
`default_nettype none

module redirection_token_splitter #(
  parameter int MAX_LEN = rts_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  rts_in_if.sink    src,
  rts_out_if.source tok
);
  import rts_pkg::*;

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);
  localparam int QD = 4;
  localparam int QA = 2;

  // Scanner state
  logic [1:0]       quote_mode, quote_mode_next;
  logic [1:0]       pending_op, pending_op_next;
  logic [POS_W-1:0] pending_pos, pending_pos_next;
  logic [POS_W-1:0] position, position_next;
  logic [POS_W-1:0] word_begin, word_begin_next;
  logic             word_has_text, word_has_text_next;
  logic             any_token_out, any_token_out_next;
  logic             error_seen, error_seen_next;

  // Tokens produced by the current byte
  rts_res_t   res_a, res_b;
  logic [1:0] res_n;

  // Result queue
  rts_res_t     queue [QD];
  logic [QA-1:0] wr_ptr, rd_ptr;
  logic [QA:0]   count;

  logic accept, pop;

  assign src.ready = (count <= (QA+1)'(QD - 2));
  assign accept    = src.valid && src.ready;
  assign tok.valid = (count != '0);
  assign pop       = tok.valid && tok.ready;

  assign tok.kind      = queue[rd_ptr].kind;
  assign tok.start_res = queue[rd_ptr].start_res;
  assign tok.length    = queue[rd_ptr].length;
  assign tok.failed    = queue[rd_ptr].failed;
  assign tok.last      = queue[rd_ptr].last;

  function automatic logic blank_byte(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic rts_res_t make_res(input logic [KIND_W-1:0] k,
                                        input logic [POS_W-1:0] s,
                                        input logic [POS_W-1:0] l,
                                        input logic f, input logic e);
    rts_res_t r;
    r.kind      = k;
    r.start_res = START_W'(s);
    r.length    = LEN_W'(l);
    r.failed    = f;
    r.last      = e;
    return r;
  endfunction

  // Append a token to the pair produced this cycle
  function automatic void push_res(input rts_res_t r, inout rts_res_t a,
                                   inout rts_res_t b, inout logic [1:0] n);
    if (n == 2'd0) begin
      a = r;
    end else begin
      b = r;
    end
    n = n + 2'd1;
  endfunction

  // Scan one byte
  always_comb begin
    logic [CH_W-1:0]   c;
    logic [KIND_W-1:0] single;
    logic              is_op;
    logic [POS_W-1:0]  p;
    logic              done;

    c      = src.ch;
    single = (pending_op == PEND_GT) ? KIND_GT : KIND_LT;
    is_op  = (c == CH_GT) || (c == CH_LT);
    p      = position;
    done   = 1'b0;

    quote_mode_next    = quote_mode;
    pending_op_next    = pending_op;
    pending_pos_next   = pending_pos;
    position_next      = position;
    word_begin_next    = word_begin;
    word_has_text_next = word_has_text;
    any_token_out_next = any_token_out;
    error_seen_next    = error_seen;
    res_a = '0;
    res_b = '0;
    res_n = 2'd0;

    if (c == CH_NUL) begin
      if (!error_seen) begin
        // Flush a held operator, then close the trailing word
        if (pending_op != PEND_NONE) begin
          push_res(make_res(single, pending_pos, POS_W'(1), 1'b0, 1'b0),
                   res_a, res_b, res_n);
          any_token_out_next = 1'b1;
          word_begin_next    = pending_pos + POS_W'(1);
          word_has_text_next = 1'b0;
        end
        if (quote_mode == QUOTE_NONE) begin
          if (word_has_text_next) begin
            push_res(make_res(KIND_WORD, word_begin_next,
                              position - word_begin_next, 1'b0, 1'b0),
                     res_a, res_b, res_n);
          end else if (any_token_out_next) begin
            error_seen_next = 1'b1;
          end
        end
      end
      push_res(make_res(KIND_END, '0, position, error_seen_next, 1'b1),
               res_a, res_b, res_n);
      // Start over for the next string
      quote_mode_next    = QUOTE_NONE;
      pending_op_next    = PEND_NONE;
      pending_pos_next   = '0;
      position_next      = '0;
      word_begin_next    = '0;
      word_has_text_next = 1'b0;
      any_token_out_next = 1'b0;
      error_seen_next    = 1'b0;
    end else if (error_seen) begin
      // Drop bytes, keep counting up to the limit
      if (position < POS_MAX) begin
        position_next = position + POS_W'(1);
      end
    end else if (position >= POS_MAX) begin
      error_seen_next = 1'b1;
    end else begin
      position_next = position + POS_W'(1);

      if (pending_op != PEND_NONE) begin
        if ((c == CH_GT && pending_op == PEND_GT) ||
            (c == CH_LT && pending_op == PEND_LT)) begin
          // Doubled operator takes this byte
          push_res(make_res(single + KIND_W'(1), pending_pos, POS_W'(2),
                            1'b0, 1'b0), res_a, res_b, res_n);
          word_begin_next = p + POS_W'(1);
          done            = 1'b1;
        end else begin
          push_res(make_res(single, pending_pos, POS_W'(1), 1'b0, 1'b0),
                   res_a, res_b, res_n);
          word_begin_next = p;
        end
        word_has_text_next = 1'b0;
        pending_op_next    = PEND_NONE;
        any_token_out_next = 1'b1;
      end

      if (!done && quote_mode == QUOTE_NONE && is_op) begin
        if (word_has_text_next) begin
          push_res(make_res(KIND_WORD, word_begin_next, p - word_begin_next,
                            1'b0, 1'b0), res_a, res_b, res_n);
          any_token_out_next = 1'b1;
          pending_op_next    = (c == CH_GT) ? PEND_GT : PEND_LT;
          pending_pos_next   = p;
        end else if (any_token_out_next) begin
          // Blank word between tokens
          error_seen_next = 1'b1;
        end else begin
          pending_op_next  = (c == CH_GT) ? PEND_GT : PEND_LT;
          pending_pos_next = p;
        end
      end else if (!done) begin
        // Toggle quotes unless the other kind is open
        if (c == CH_SQ && quote_mode != QUOTE_DOUBLE) begin
          quote_mode_next = (quote_mode == QUOTE_NONE) ? QUOTE_SINGLE : QUOTE_NONE;
        end else if (c == CH_DQ && quote_mode != QUOTE_SINGLE) begin
          quote_mode_next = (quote_mode == QUOTE_NONE) ? QUOTE_DOUBLE : QUOTE_NONE;
        end
        if (!blank_byte(c)) begin
          word_has_text_next = 1'b1;
        end
      end
    end
  end

  // Scanner state register; advance only on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode    <= QUOTE_NONE;
      pending_op    <= PEND_NONE;
      pending_pos   <= '0;
      position      <= '0;
      word_begin    <= '0;
      word_has_text <= 1'b0;
      any_token_out <= 1'b0;
      error_seen    <= 1'b0;
    end else if (accept) begin
      quote_mode    <= quote_mode_next;
      pending_op    <= pending_op_next;
      pending_pos   <= pending_pos_next;
      position      <= position_next;
      word_begin    <= word_begin_next;
      word_has_text <= word_has_text_next;
      any_token_out <= any_token_out_next;
      error_seen    <= error_seen_next;
    end
  end

  // Queue payload: write up to two entries per beat
  always_ff @(posedge clk) begin
    if (accept && res_n != 2'd0) begin
      queue[wr_ptr] <= res_a;
      if (res_n == 2'd2) begin
        queue[wr_ptr + QA'(1)] <= res_b;
      end
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    logic [QA:0] push_n;
    push_n = accept ? (QA+1)'(res_n) : '0;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QA'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + QA'(1);
      end
      count <= count + push_n - (QA+1)'(pop);
    end
  end

endmodule

`default_nettype wire

>>> tb/rts_token_checker.sv
// Token checker for the redirection token splitter: watches both channels,
// predicts the tokens of every accepted byte and compares them in order.
// Depends on rts_pkg and the channel interfaces in rts_ifs.sv.

module rts_token_checker #(
  parameter int MAX_LEN = rts_pkg::MAX_LEN_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  rts_in_if    src,
  rts_out_if   tok,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rts_pkg::*;

  // scanner state of the string being split
  logic [1:0]  quote_st;
  logic [1:0]  op_held;
  logic [11:0] op_pos;
  logic [12:0] pos_cnt;
  logic [12:0] word_from;
  logic        has_text;
  logic        tok_sent;
  logic        err_flag;

  rts_res_t expected_tokens[$];
  rts_res_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic bit is_blank(logic [CH_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void expect_tok(logic [KIND_W-1:0] kind, logic [START_W-1:0] start,
                                     logic [LEN_W-1:0] len, logic failed, logic last);
    rts_res_t t;
    t.kind      = kind;
    t.start_res = start;
    t.length    = len;
    t.failed    = failed;
    t.last      = last;
    expected_tokens.push_back(t);
  endfunction

  function automatic void clear_string();
    quote_st  = QUOTE_NONE;
    op_held   = PEND_NONE;
    op_pos    = '0;
    pos_cnt   = '0;
    word_from = '0;
    has_text  = 1'b0;
    tok_sent  = 1'b0;
    err_flag  = 1'b0;
  endfunction

  function automatic void split_byte(logic [CH_W-1:0] c);
    logic [12:0] p;
    if (c == CH_NUL) begin
      if (!err_flag) begin
        // flush a held operator as its single form
        if (op_held != PEND_NONE) begin
          expect_tok(op_held == PEND_GT ? KIND_GT : KIND_LT, op_pos, 13'd1, 1'b0, 1'b0);
          tok_sent  = 1'b1;
          word_from = {1'b0, op_pos} + 13'd1;
          has_text  = 1'b0;
          op_held   = PEND_NONE;
        end
        // trailing word is dropped while a quote is open
        if (quote_st == QUOTE_NONE) begin
          if (has_text)
            expect_tok(KIND_WORD, word_from[11:0], pos_cnt - word_from, 1'b0, 1'b0);
          else if (tok_sent)
            err_flag = 1'b1;
        end
      end
      expect_tok(KIND_END, '0, pos_cnt, err_flag, 1'b1);
      clear_string();
      return;
    end

    if (err_flag) begin
      if (pos_cnt < MAX_LEN)
        pos_cnt = pos_cnt + 13'd1;
      return;
    end
    if (pos_cnt >= MAX_LEN) begin
      err_flag = 1'b1;
      return;
    end
    p       = pos_cnt;
    pos_cnt = pos_cnt + 13'd1;

    if (op_held != PEND_NONE) begin
      if ((c == CH_GT && op_held == PEND_GT) || (c == CH_LT && op_held == PEND_LT)) begin
        expect_tok(op_held == PEND_GT ? KIND_GTGT : KIND_LTLT, op_pos, 13'd2, 1'b0, 1'b0);
        word_from = p + 13'd1;
        has_text  = 1'b0;
        op_held   = PEND_NONE;
        tok_sent  = 1'b1;
        return;
      end
      expect_tok(op_held == PEND_GT ? KIND_GT : KIND_LT, op_pos, 13'd1, 1'b0, 1'b0);
      word_from = p;
      has_text  = 1'b0;
      op_held   = PEND_NONE;
      tok_sent  = 1'b1;
    end

    if (quote_st == QUOTE_NONE && (c == CH_GT || c == CH_LT)) begin
      if (has_text) begin
        expect_tok(KIND_WORD, word_from[11:0], p - word_from, 1'b0, 1'b0);
        tok_sent = 1'b1;
      end else if (tok_sent) begin
        err_flag = 1'b1;
        return;
      end
      op_held = (c == CH_GT) ? PEND_GT : PEND_LT;
      op_pos  = p[11:0];
      return;
    end

    if (c == CH_SQ && quote_st != QUOTE_DOUBLE)
      quote_st = (quote_st == QUOTE_NONE) ? QUOTE_SINGLE : QUOTE_NONE;
    else if (c == CH_DQ && quote_st != QUOTE_SINGLE)
      quote_st = (quote_st == QUOTE_NONE) ? QUOTE_DOUBLE : QUOTE_NONE;
    if (!is_blank(c))
      has_text = 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_string();
      expected_tokens.delete();
    end else begin
      // take the input beat first so a same-edge token still finds its entry
      if (src.valid && src.ready)
        split_byte(src.ch);
      if (tok.valid && tok.ready) begin
        if (expected_tokens.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected token: expected none, actual kind %0d start %0d len %0d",
                   $time, tok.kind, tok.start_res, tok.length);
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind", 32'(want.kind), 32'(tok.kind));
          check_field("start_res", 32'(want.start_res), 32'(tok.start_res));
          check_field("length", 32'(want.length), 32'(tok.length));
          check_field("failed", 32'(want.failed), 32'(tok.failed));
          check_field("last", 32'(want.last), 32'(tok.last));
        end
      end
    end
    pending = expected_tokens.size();
  end

endmodule

>>> tb/redirection_token_splitter_tb.sv
// Top of the redirection token splitter testbench: clock, reset, byte stimulus,
// token-side backpressure and the verdict. Depends on rts_pkg, rts_ifs.sv,
// the splitter RTL and rts_token_checker.

module redirection_token_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rts_pkg::*;

  localparam int MAX_LEN = MAX_LEN_DEFAULT;

  logic clk = 1'b0;
  logic rst;

  // percent of cycles in which each side holds off
  int src_idle;
  int snk_idle;
  int bytes_sent;
  int fail_count;
  int pending;

  rts_in_if  src_ch ();
  rts_out_if tok_ch ();

  redirection_token_splitter #(.MAX_LEN(MAX_LEN)) i_dut (
    .clk (clk),
    .rst (rst),
    .src (src_ch),
    .tok (tok_ch)
  );

  rts_token_checker #(.MAX_LEN(MAX_LEN)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .src        (src_ch),
    .tok        (tok_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Token side: decide ready once per cycle at the falling edge.
  always @(negedge clk) begin
    tok_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  // Send one byte. Called at a falling edge and returns at a falling edge, so
  // valid gets at most one update per time step. Idle cycles drop valid and
  // scramble ch so the block cannot lean on a stale byte.
  task automatic push_byte(input logic [CH_W-1:0] b);
    while ($urandom_range(0, 99) < src_idle) begin
      src_ch.valid <= 1'b0;
      src_ch.ch    <= CH_W'($urandom_range(0, 255));
      @(negedge clk);
    end
    src_ch.valid <= 1'b1;
    src_ch.ch    <= b;
    // ready is read before the edge's register updates land
    do @(posedge clk); while (!src_ch.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Fixed text followed by the terminator.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i]);
    push_byte(CH_NUL);
  endtask

  // Byte that is plain word text: not blank, not a quote, not an operator.
  function automatic logic [CH_W-1:0] plain_char();
    logic [CH_W-1:0] c;
    do c = CH_W'($urandom_range(1, 255));
    while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_SQ || c == CH_DQ ||
           c == CH_GT || c == CH_LT);
    return c;
  endfunction

  function automatic logic [CH_W-1:0] blank_char();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? CH_SPACE : CH_W'(r);
  endfunction

  task automatic send_blanks(input int max_n);
    int n;
    n = $urandom_range(0, max_n);
    repeat (n) push_byte(blank_char());
  endtask

  // Word built from plain runs and quoted runs; quoted runs may hold anything
  // but the terminator and their own closing quote, operators included.
  task automatic send_word();
    int segs;
    int n;
    logic [CH_W-1:0] q;
    logic [CH_W-1:0] c;
    segs = $urandom_range(1, 3);
    repeat (segs) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          q = ($urandom_range(0, 1) != 0) ? CH_SQ : CH_DQ;
          push_byte(q);
          n = $urandom_range(0, 4);
          repeat (n) begin
            do c = CH_W'($urandom_range(1, 255)); while (c == q);
            push_byte(c);
          end
          push_byte(q);
        end
        default: begin
          n = $urandom_range(1, 4);
          repeat (n) push_byte(plain_char());
        end
      endcase
    end
  endtask

  task automatic send_op();
    case ($urandom_range(0, 3))
      0: push_byte(CH_GT);
      1: begin push_byte(CH_GT); push_byte(CH_GT); end
      2: push_byte(CH_LT);
      default: begin push_byte(CH_LT); push_byte(CH_LT); end
    endcase
  endtask

  // One random command. Most are well formed (words and operators separated by
  // optional blanks) so the scanner gets deep; the rest are raw noise or a
  // jumble of operators, quotes and blanks that breaks the grammar.
  task automatic send_rand_command();
    int style;
    int n;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      n = $urandom_range(1, 16);
      repeat (n) push_byte(CH_W'($urandom_range(1, 255)));
    end else if (style == 1) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: push_byte(CH_GT);
          1: push_byte(CH_LT);
          2: push_byte(CH_SPACE);
          3: push_byte(CH_SQ);
          4: push_byte(CH_DQ);
          default: push_byte(plain_char());
        endcase
      end
    end else begin
      send_blanks(2);
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 2) == 0) begin
          send_op();
          send_blanks(1);
        end
        send_word();
        send_blanks(1);
      end
      // now and then leave a quote open at the terminator
      if ($urandom_range(0, 15) == 0) begin
        push_byte(($urandom_range(0, 1) != 0) ? CH_SQ : CH_DQ);
        push_byte(plain_char());
      end
    end
    push_byte(CH_NUL);
  endtask

  initial begin
    rst          = 1'b1;
    src_ch.valid = 1'b0;
    src_ch.ch    = '0;
    tok_ch.ready = 1'b0;
    src_idle     = 30;
    snk_idle     = 51;
    bytes_sent   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed strings:
    //   empty string, terminator only
    //   word, doubled > and <, words between
    //   leading blank skipped, operator ended by an open quote that hides
    //   a quote of the other kind and an operator, word dropped at the end
    //   blank word after a token, then a byte ignored after the error
    //   top byte value as a word, operator held at the terminator
    //   quoted operator inside a word, trailing carriage return
    send_text("");
    send_text("a>>b<<c");
    send_text("\011<'\">");
    send_text("a> >z");
    send_text("\377<");
    send_text("\"a<\"\015");

    // sender idles lightly while the token side stalls often
    while (bytes_sent < 560)
      send_rand_command();
    // swap the pressure
    src_idle = 51;
    snk_idle = 30;
    while (bytes_sent < 1100)
      send_rand_command();
    // full rate on both sides
    src_idle = 0;
    snk_idle = 0;
    while (bytes_sent < 1630)
      send_rand_command();
    src_ch.valid <= 1'b0;

    // drain, then give stray tokens a chance to show up
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
